>>> hdl/eitr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the EIT actual-to-other rewriter.
// No dependencies; every other file in hdl/ but eitr_if.sv uses this package.
package eitr_pkg;

	localparam int unsigned MaxSectionDefault = 4096;
	localparam int unsigned QueueDepth        = 4;

	localparam logic [7:0] TidActualPf   = 8'h4E;
	localparam logic [7:0] TidOtherPf    = 8'h4F;
	localparam logic [7:0] TidActualSchLo = 8'h50;
	localparam logic [7:0] TidActualSchHi = 8'h5F;
	localparam logic [7:0] TidOtherSchBase = 8'h60;

	localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
	localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		MODE_CRC_ONLY,
		MODE_TBL_4E,
		MODE_TBL_5X,
		MODE_RAW
	} mode_t;

	// One request from the front to the back: either the three header bytes
	// or a single body byte.
	typedef struct packed {
		logic       hdr;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       crc_upd;
		logic       crc_sub;
		logic [1:0] crc_sel;
		logic       last;
	} entry_t;

	function automatic logic [7:0] rewrite_byte(input mode_t mode, input logic [7:0] v);
		logic [7:0] r;
		unique case (mode)
			MODE_TBL_4E: r = TidOtherPf;
			MODE_TBL_5X: r = TidOtherSchBase | {4'h0, v[3:0]};
			default:     r = v;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] crc8_update(input logic [31:0] crc, input logic [7:0] v);
		logic [31:0] c;
		c = crc ^ {v, 24'h0};
		for (int b = 0; b < 8; b++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/eitr_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces of the rewriter: byte input and result output.
// No dependencies.
interface eitr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface eitr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       section_end;
	logic       run_last;

	modport source (output valid, output out_byte, output section_end, output run_last,
		input ready);
	modport sink   (input valid, input out_byte, input section_end, input run_last,
		output ready);
endinterface

>>> hdl/eit_section_actual_to_other_rewriter.sv
`timescale 1ns / 1ps
// EIT actual-to-other section rewriter with CRC-32/MPEG-2 regeneration.
// Channels: din carries one stream byte per request (valid/ready); dout carries
// one result per request: out_byte, section_end on the last byte of a section,
// run_last on the last result caused by an input byte.
// Bytes 0 and 1 of a section give no result; byte 2 gives three (the header),
// every later byte gives one. In sections with a length field of four or more,
// the last four bytes are replaced by the CRC, most significant byte first, and
// tables 0x4E and 0x50..0x5F are rewritten. Throughput: one byte per cycle while
// dout.ready stays high; the front end takes a byte each cycle and the back end
// sends one result each cycle, the three header results back to back, which the
// two idle header bytes pay for. A body byte goes from its accept through the
// request queue and then the output register to dout.
// A stalled receiver holds the output register; the four-entry queue fills and
// then din.ready falls. A section longer than MAX_SECTION_BYTES halts the block:
// all later bytes are accepted and dropped. Reset clears position, mode, CRC
// and the halt, and empties the queue and output register.
// Uses eitr_pkg, eitr_if, eitr_front, eitr_fifo, eitr_back.
module eit_section_actual_to_other_rewriter #(
	parameter int unsigned MAX_SECTION_BYTES = eitr_pkg::MaxSectionDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	eitr_in_if.sink     din,
	eitr_out_if.source  dout
);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_not_empty;
	eitr_pkg::entry_t wr_entry;
	eitr_pkg::entry_t rd_entry;

	eitr_front #(
		.MAX_SECTION_BYTES(MAX_SECTION_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (wr_entry)
	);

	eitr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (wr_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_entry  (rd_entry)
	);

	eitr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_entry     (rd_entry),
		.q_pop       (q_pop),
		.dout        (dout)
	);

endmodule

>>> hdl/eitr_front.sv
`timescale 1ns / 1ps
// Front end: tracks section boundaries, holds the header, picks the rewrite mode
// and turns the header and each later byte into a back-end request. Uses eitr_pkg, eitr_in_if.
module eitr_front #(
	parameter int unsigned MAX_SECTION_BYTES = eitr_pkg::MaxSectionDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	eitr_in_if.sink            din,
	input  logic               q_full,
	output logic               q_push,
	output eitr_pkg::entry_t   q_entry
);

	logic [11:0]     pos_q;
	logic [12:0]     total_q;
	eitr_pkg::mode_t mode_q;
	logic [7:0]      hold0_q;
	logic [7:0]      hold1_q;
	logic            halted_q;

	logic            take;
	logic [11:0]     len;
	logic [12:0]     total;
	logic            oversize;
	eitr_pkg::mode_t mode_new;
	logic [12:0]     idx;
	logic [12:0]     crc_start;
	logic [12:0]     crc_off;
	logic            body_last;

	// Drop everything once halted.
	assign din.ready = halted_q || !q_full;
	assign take      = din.valid && din.ready && !halted_q;

	assign len       = {hold1_q[3:0], din.in_byte};
	assign total     = {1'b0, len} + 13'd3;
	assign oversize  = total > 13'(MAX_SECTION_BYTES);
	assign idx       = {1'b0, pos_q};
	assign crc_start = total_q - 13'd4;
	assign crc_off   = idx - crc_start;
	assign body_last = (idx + 13'd1) == total_q;

	always_comb begin
		if (len < 12'd4) begin
			mode_new = eitr_pkg::MODE_RAW;
		end else if (hold0_q == eitr_pkg::TidActualPf) begin
			mode_new = eitr_pkg::MODE_TBL_4E;
		end else if (hold0_q >= eitr_pkg::TidActualSchLo &&
				hold0_q <= eitr_pkg::TidActualSchHi) begin
			mode_new = eitr_pkg::MODE_TBL_5X;
		end else begin
			mode_new = eitr_pkg::MODE_CRC_ONLY;
		end
	end

	always_comb begin
		q_entry = '0;
		q_push  = 1'b0;
		if (pos_q == 12'd2) begin
			q_push          = take && !oversize;
			q_entry.hdr     = 1'b1;
			q_entry.b0      = eitr_pkg::rewrite_byte(mode_new, hold0_q);
			q_entry.b1      = hold1_q;
			q_entry.b2      = din.in_byte;
			q_entry.crc_upd = mode_new != eitr_pkg::MODE_RAW;
			q_entry.last    = total == 13'd3;
		end else begin
			q_push          = take && pos_q > 12'd2;
			q_entry.hdr     = 1'b0;
			q_entry.b2      = (pos_q == 12'd13) ?
				eitr_pkg::rewrite_byte(mode_q, din.in_byte) : din.in_byte;
			q_entry.crc_upd = mode_q != eitr_pkg::MODE_RAW;
			q_entry.crc_sub = mode_q != eitr_pkg::MODE_RAW && idx >= crc_start;
			q_entry.crc_sel = crc_off[1:0];
			q_entry.last    = body_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			total_q  <= '0;
			mode_q   <= eitr_pkg::MODE_CRC_ONLY;
			halted_q <= 1'b0;
		end else if (take) begin
			priority case (pos_q)
				12'd0: pos_q <= 12'd1;
				12'd1: pos_q <= 12'd2;
				12'd2: begin
					total_q <= total;
					mode_q  <= mode_new;
					if (oversize) begin
						halted_q <= 1'b1;
					end else begin
						pos_q <= (total == 13'd3) ? 12'd0 : 12'd3;
					end
				end
				default: pos_q <= body_last ? 12'd0 : pos_q + 12'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && pos_q == 12'd0) begin
			hold0_q <= din.in_byte;
		end
		if (take && pos_q == 12'd1) begin
			hold1_q <= din.in_byte;
		end
	end

endmodule

>>> hdl/eitr_fifo.sv
`timescale 1ns / 1ps
// Short request queue between front and back end.
// Uses eitr_pkg for the entry type and depth.
module eitr_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  eitr_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output eitr_pkg::entry_t rd_entry
);

	localparam int unsigned Depth = eitr_pkg::QueueDepth;
	localparam int unsigned PtrW  = $clog2(Depth);
	localparam int unsigned CntW  = $clog2(Depth + 1);

	eitr_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = cnt_q == CntW'(Depth);
	assign not_empty = cnt_q != '0;
	assign rd_entry  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

>>> hdl/eitr_back.sv
`timescale 1ns / 1ps
// Back end: runs the CRC-32/MPEG-2, substitutes the CRC bytes, splits header
// requests into three results and drives the output register. Uses eitr_pkg.
module eitr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  eitr_pkg::entry_t q_entry,
	output logic             q_pop,
	eitr_out_if.source       dout
);

	logic [1:0]  sub_q;
	logic [31:0] crc_q;
	logic        ov_q;
	logic [7:0]  ob_q;
	logic        oend_q;
	logic        olast_q;

	logic        load;
	logic [7:0]  cur;
	logic [7:0]  crc_byte;
	logic [7:0]  obyte;
	logic        run_last;
	logic        cur_last;

	assign load     = q_not_empty && (!ov_q || dout.ready);
	assign run_last = !q_entry.hdr || sub_q == 2'd2;
	assign cur_last = q_entry.last && run_last;
	assign q_pop    = load && run_last;

	always_comb begin
		if (!q_entry.hdr) begin
			cur = q_entry.b2;
		end else begin
			unique case (sub_q)
				2'd0:    cur = q_entry.b0;
				2'd1:    cur = q_entry.b1;
				default: cur = q_entry.b2;
			endcase
		end
		unique case (q_entry.crc_sel)
			2'd0: crc_byte = crc_q[31:24];
			2'd1: crc_byte = crc_q[23:16];
			2'd2: crc_byte = crc_q[15:8];
			2'd3: crc_byte = crc_q[7:0];
		endcase
		obyte = q_entry.crc_sub ? crc_byte : cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
			crc_q <= eitr_pkg::CrcInit;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				ov_q  <= 1'b1;
				sub_q <= run_last ? 2'd0 : sub_q + 2'd1;
				if (cur_last) begin
					crc_q <= eitr_pkg::CrcInit;
				end else if (q_entry.crc_upd && !q_entry.crc_sub) begin
					crc_q <= eitr_pkg::crc8_update(crc_q, cur);
				end
			end else if (dout.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ob_q    <= obyte;
			oend_q  <= cur_last;
			olast_q <= run_last;
		end
	end

	assign dout.valid       = ov_q;
	assign dout.out_byte    = ob_q;
	assign dout.section_end = oend_q;
	assign dout.run_last    = olast_q;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench of eit_section_actual_to_other_rewriter: random section streams with a
// scoreboard that predicts every result byte, table rewrite and CRC-32/MPEG-2.
// Depends on eitr_pkg, eitr_if and the rewriter RTL.
module testbench;

	localparam int unsigned CycleLimit    = 3_000_000;
	localparam int unsigned DrainCycles   = 20;
	localparam int unsigned RandomItems   = 330;
	localparam int unsigned OversizeBytes = 15;

	typedef struct {
		logic [7:0] out_byte;
		logic       section_end;
		logic       run_last;
	} eit_result_t;

	class eit_scoreboard;
		eit_result_t expected_results[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned sections_by_mode[4];
		bit          halted;
		int unsigned position;
		int unsigned section_total;
		logic [7:0]  hold_tid;
		logic [7:0]  hold_len_hi;
		eitr_pkg::mode_t mode;
		logic [31:0] crc;

		function new();
			errors = 0;
			checked = 0;
			halted = 1'b0;
			position = 0;
			section_total = 0;
			mode = eitr_pkg::MODE_CRC_ONLY;
			crc = eitr_pkg::CrcInit;
		endfunction

		// Bit-serial MSB-first CRC, one data bit per shift.
		function logic [31:0] crc_mpeg2_step(logic [31:0] c, logic [7:0] d);
			logic [31:0] r;
			logic        fb;
			r = c;
			for (int i = 7; i >= 0; i--) begin
				fb = r[31] ^ d[i];
				r = {r[30:0], 1'b0};
				if (fb) begin
					r = r ^ eitr_pkg::CrcPoly;
				end
			end
			return r;
		endfunction

		function logic [7:0] retarget_table(logic [7:0] v);
			case (mode)
				eitr_pkg::MODE_TBL_4E: return eitr_pkg::TidOtherPf;
				eitr_pkg::MODE_TBL_5X: return eitr_pkg::TidOtherSchBase | (v & 8'h0F);
				default:               return v;
			endcase
		endfunction

		function void emit_result(int unsigned idx, logic [7:0] v);
			eit_result_t r;
			r.out_byte = v;
			r.section_end = (idx + 1 == section_total);
			r.run_last = 1'b0;
			if (mode != eitr_pkg::MODE_RAW && section_total >= 4 &&
					idx >= section_total - 4) begin
				// Substitute the CRC, most significant byte first.
				r.out_byte = crc[8 * (3 - (idx - (section_total - 4))) +: 8];
			end else begin
				if (idx == 0 || idx == 13) begin
					r.out_byte = retarget_table(v);
				end
				if (mode != eitr_pkg::MODE_RAW) begin
					crc = crc_mpeg2_step(crc, r.out_byte);
				end
			end
			expected_results.push_back(r);
			if (r.section_end) begin
				position = 0;
				crc = eitr_pkg::CrcInit;
			end else begin
				position = (idx + 1) & 12'hFFF;
			end
		endfunction

		function void note_byte(logic [7:0] v);
			int unsigned len;
			if (halted) begin
				return;
			end
			case (position)
				0: begin
					hold_tid = v;
					position = 1;
				end
				1: begin
					hold_len_hi = v;
					position = 2;
				end
				2: begin
					len = 32'({hold_len_hi[3:0], v});
					section_total = len + 3;
					if (section_total > eitr_pkg::MaxSectionDefault) begin
						halted = 1'b1;
						return;
					end
					if (len < 4) begin
						mode = eitr_pkg::MODE_RAW;
					end else if (hold_tid == eitr_pkg::TidActualPf) begin
						mode = eitr_pkg::MODE_TBL_4E;
					end else if (hold_tid >= eitr_pkg::TidActualSchLo &&
							hold_tid <= eitr_pkg::TidActualSchHi) begin
						mode = eitr_pkg::MODE_TBL_5X;
					end else begin
						mode = eitr_pkg::MODE_CRC_ONLY;
					end
					sections_by_mode[int'(mode)]++;
					crc = eitr_pkg::CrcInit;
					emit_result(0, hold_tid);
					emit_result(1, hold_len_hi);
					emit_result(2, v);
					expected_results[expected_results.size() - 1].run_last = 1'b1;
				end
				default: begin
					emit_result(position, v);
					expected_results[expected_results.size() - 1].run_last = 1'b1;
				end
			endcase
		endfunction

		function void check_result(logic [7:0] o, logic se, logic rl);
			eit_result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result out_byte=%02h section_end=%0b run_last=%0b",
					$time, o, se, rl);
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (o !== want.out_byte) begin
				errors++;
				$display("%0t: out_byte expected %02h got %02h", $time, want.out_byte, o);
			end
			if (se !== want.section_end) begin
				errors++;
				$display("%0t: section_end expected %0b got %0b", $time, want.section_end, se);
			end
			if (rl !== want.run_last) begin
				errors++;
				$display("%0t: run_last expected %0b got %0b", $time, want.run_last, rl);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned stall_left = 0;
	int unsigned quiet_left = 0;
	eit_scoreboard sb = new();

	eitr_in_if  din_if();
	eitr_out_if dout_if();

	eit_section_actual_to_other_rewriter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: check every accepted result, then pick the next ready level.
	always @(posedge clk) begin
		int unsigned roll;
		if (arst_n && dout_if.valid && dout_if.ready) begin
			sb.check_result(dout_if.out_byte, dout_if.section_end, dout_if.run_last);
		end
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else if (quiet_left != 0) begin
			quiet_left--;
			dout_if.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			dout_if.ready <= 1'b0;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				quiet_left = $urandom_range(20, 150);
			end else if (roll < 20) begin
				stall_left = $urandom_range(0, 2);
			end else if (roll < 23) begin
				stall_left = $urandom_range(8, 40);
			end
			dout_if.ready <= (roll >= 4 && roll < 23) ? 1'b0 : 1'b1;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [7:0] pick_tid();
		int unsigned roll;
		logic [7:0]  nib;
		roll = $urandom_range(0, 99);
		nib = 8'($urandom_range(0, 15));
		if (roll < 30) begin
			return eitr_pkg::TidActualPf;
		end
		if (roll < 60) begin
			return eitr_pkg::TidActualSchLo | nib;
		end
		if (roll < 70) begin
			case ($urandom_range(0, 5))
				0: return eitr_pkg::TidOtherPf;
				1: return eitr_pkg::TidOtherSchBase;
				2: return eitr_pkg::TidOtherSchBase | 8'h0F;
				3: return eitr_pkg::TidActualPf - 8'd1;
				4: return 8'h00;
				default: return 8'hFF;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Mostly short sections; lengths 10..16 put byte 13 around the CRC bytes.
	function automatic logic [11:0] pick_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			return 12'($urandom_range(10, 16));
		end
		if (roll < 20) begin
			return 12'($urandom_range(0, 3));
		end
		if (roll < 65) begin
			return 12'($urandom_range(4, 24));
		end
		if (roll < 92) begin
			return 12'($urandom_range(25, 80));
		end
		return 12'($urandom_range(100, 300));
	endfunction

	task automatic send_byte(input logic [7:0] v, input bit burst);
		int unsigned gap;
		gap = burst ? 0 : pick_gap();
		din_if.valid <= 1'b1;
		din_if.in_byte <= v;
		do @(posedge clk); while (!din_if.ready);
		sb.note_byte(v);
		bytes_sent++;
		if (gap != 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_section(input logic [7:0] tid, input logic [3:0] hi_junk,
		input logic [11:0] len, input bit burst);
		send_byte(tid, burst);
		send_byte({hi_junk, len[11:8]}, burst);
		send_byte(len[7:0], burst);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)), burst);
		end
	endtask

	// Hold off the sender until every expected result has come.
	task automatic drain_results();
		din_if.valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned target;
		int unsigned room;
		logic [11:0] len;
		din_if.valid <= 1'b0;
		din_if.in_byte <= 8'h00;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero-length section: three header results on one request.
		send_section(8'hFF, 4'hF, 12'd0, 1'b1);
		// Short section of table 4E: pass through untouched.
		send_section(eitr_pkg::TidActualPf, 4'h0, 12'd3, 1'b0);
		// Smallest section with a CRC: all four body bytes replaced.
		send_section(eitr_pkg::TidActualSchLo, 4'($urandom_range(0, 15)), 12'd4, 1'b0);
		send_byte(eitr_pkg::TidActualSchHi, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h04, 1'b1);
		for (int i = 0; i < 4; i++) begin
			send_byte((i % 2 == 0) ? 8'h00 : 8'hFF, 1'b1);
		end
		drain_results();

		target = RandomItems - OversizeBytes;
		while (bytes_sent < target) begin
			// Keep the section within the remaining byte budget.
			room = target - bytes_sent;
			len = pick_len();
			if (32'(len) + 3 > room) begin
				len = (room > 3) ? 12'(room - 3) : 12'd0;
			end
			send_section(pick_tid(), 4'($urandom_range(0, 15)), len,
				$urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				drain_results();
			end
		end

		// Oversize section: halt, drop the header and every later byte.
		len = 12'($urandom_range(eitr_pkg::MaxSectionDefault - 2, 4095));
		send_byte(pick_tid(), 1'b0);
		send_byte({4'($urandom_range(0, 15)), len[11:8]}, 1'b0);
		send_byte(len[7:0], 1'b0);
		repeat (OversizeBytes - 3) send_byte(8'($urandom_range(0, 255)), 1'b0);

		drain_results();
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d bytes: %0d sections of table 4E, %0d of tables 50-5F,",
			bytes_sent, sb.sections_by_mode[int'(eitr_pkg::MODE_TBL_4E)],
			sb.sections_by_mode[int'(eitr_pkg::MODE_TBL_5X)]);
		$display("%0d CRC only, %0d short; checked %0d results; oversize halt reached: %0b",
			sb.sections_by_mode[int'(eitr_pkg::MODE_CRC_ONLY)],
			sb.sections_by_mode[int'(eitr_pkg::MODE_RAW)], sb.checked, sb.halted);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
